>>> hdl/i2cwe_pkg.sv
// ----------------------------------------------------------------------------
// i2cwe_pkg: shared types and constants of the i2c controller write engine
// transaction payloads, command codes, register indexes and reset values
// ----------------------------------------------------------------------------
package i2cwe_pkg;

   // default width of the phase tick counter
   localparam int TICK_COUNT_WIDTH = 8;

   // command codes carried in the action field
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_SEND  = 2'd2;
   localparam logic [1:0] ACT_STOP  = 2'd3;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_ADDRESS      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BUS_FREE_TICKS      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BIT_LOW_TICKS       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DATA_SETUP_TICKS    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BIT_HIGH_TICKS      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACK_LOW_TICKS       = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACK_HALF_HIGH_TICKS = 3'd6;

   // register reset values
   localparam logic [6:0] RST_TARGET_ADDRESS      = 7'd0;
   localparam logic [7:0] RST_BUS_FREE_TICKS      = 8'd5;
   localparam logic [7:0] RST_BIT_LOW_TICKS       = 8'd4;
   localparam logic [7:0] RST_DATA_SETUP_TICKS    = 8'd2;
   localparam logic [7:0] RST_BIT_HIGH_TICKS      = 8'd6;
   localparam logic [7:0] RST_ACK_LOW_TICKS       = 8'd6;
   localparam logic [7:0] RST_ACK_HALF_HIGH_TICKS = 8'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic scl_release;
      logic sda_release;
      logic busy_res;
      logic ack_done;
      logic acked;
      logic rejected;
   } rsp_type;

endpackage

>>> hdl/i2c_controller_write_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_controller_write_engine_top: tick-driven i2c controller transmitter
// start with address, byte send with ack sample, and stop, one tick per transaction
// ----------------------------------------------------------------------------
// Every request transaction is one time tick of the bus engine and returns
// exactly one response transaction carrying the scl/sda release levels, busy,
// ack status and a reject flag. The engine takes one transaction per clock:
// the phase sequencer updates its state in the same cycle as acceptance and
// the response sits in an output register, so it appears in the cycle
// after acceptance and a new request is taken in every cycle in which the
// response register is empty or being drained. Phase lengths come from the
// csr registers; a zero length acts as one and lengths above the tick counter
// range clamp to its maximum. Commands issued while a sequence runs are
// ignored and flagged as rejected, but still count as a tick. Configuration
// writes take effect on the next clock.
module i2c_controller_write_engine_top #(
   parameter int TICK_COUNT_WIDTH = i2cwe_pkg::TICK_COUNT_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  i2cwe_pkg::req_type                       req_data,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output i2cwe_pkg::rsp_type                       rsp_data,
   // configuration write port
   input  logic                                     csr_we,
   input  logic [i2cwe_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [i2cwe_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // compare width covers both the counter and the 8-bit registers
   localparam int LW = (TICK_COUNT_WIDTH > 8) ? TICK_COUNT_WIDTH : 8;
   localparam logic [LW-1:0] CNT_MAX = LW'((2 ** TICK_COUNT_WIDTH) - 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_BUSFREE,
      PH_STARTHOLD,
      PH_BITLOW,
      PH_BITSETUP,
      PH_BITHIGH,
      PH_ACKLOW,
      PH_ACKH1,
      PH_ACKH2,
      PH_STOPLOW,
      PH_STOPHIGH
   } phase_type;

   // configuration registers
   logic [6:0] target_address_ff;
   logic [7:0] bus_free_ticks_ff;
   logic [7:0] bit_low_ticks_ff;
   logic [7:0] data_setup_ticks_ff;
   logic [7:0] bit_high_ticks_ff;
   logic [7:0] ack_low_ticks_ff;
   logic [7:0] ack_half_high_ticks_ff;

   // sequencer state
   phase_type                     phase_ff,      phase_in;
   logic [TICK_COUNT_WIDTH-1:0]   tick_count_ff, tick_count_in;
   logic [2:0]                    bit_index_ff,  bit_index_in;
   logic [7:0]                    shift_byte_ff, shift_byte_in;
   logic                          scl_line_ff,   scl_line_in;
   logic                          sda_line_ff,   sda_line_in;

   // response register
   logic                rsp_valid_ff;
   i2cwe_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic [7:0]                  len_sel;
   logic [TICK_COUNT_WIDTH-1:0] len_clamped;
   logic [TICK_COUNT_WIDTH-1:0] cnt_inc;
   logic                        phase_done;
   logic                        ack_done;
   logic                        acked;
   logic                        rejected;

   // a request is taken whenever the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // length of the running phase
   always_comb begin
      case (phase_ff)
         PH_BITLOW:   len_sel = bit_low_ticks_ff;
         PH_BITSETUP: len_sel = data_setup_ticks_ff;
         PH_BITHIGH:  len_sel = bit_high_ticks_ff;
         PH_ACKLOW:   len_sel = ack_low_ticks_ff;
         PH_ACKH1,
         PH_ACKH2:    len_sel = ack_half_high_ticks_ff;
         default:     len_sel = bus_free_ticks_ff;
      endcase
   end

   // zero acts as one, anything past the counter range clamps to its maximum
   always_comb begin
      if (len_sel == 8'd0) begin
         len_clamped = TICK_COUNT_WIDTH'(1);
      end else if (LW'(len_sel) > CNT_MAX) begin
         len_clamped = CNT_MAX[TICK_COUNT_WIDTH-1:0];
      end else begin
         len_clamped = TICK_COUNT_WIDTH'(LW'(len_sel));
      end
   end

   assign cnt_inc    = tick_count_ff + TICK_COUNT_WIDTH'(1);
   assign phase_done = (cnt_inc >= len_clamped);

   // next state of the phase sequencer for the transaction being accepted
   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      scl_line_in   = scl_line_ff;
      sda_line_in   = sda_line_ff;
      ack_done      = 1'b0;
      acked         = 1'b0;
      rejected      = 1'b0;

      if (phase_ff != PH_IDLE) begin
         // running sequence: any command is dropped, the tick still counts
         rejected      = (req_data.action != i2cwe_pkg::ACT_TICK);
         tick_count_in = cnt_inc;
         if (phase_done) begin
            tick_count_in = '0;
            unique case (phase_ff)
               PH_BUSFREE: begin
                  sda_line_in = 1'b0;
                  phase_in    = PH_STARTHOLD;
               end
               PH_STARTHOLD: begin
                  // address byte with write bit in the lsb
                  scl_line_in   = 1'b0;
                  shift_byte_in = {target_address_ff, 1'b0};
                  bit_index_in  = '0;
                  phase_in      = PH_BITLOW;
               end
               PH_BITLOW: begin
                  sda_line_in = shift_byte_ff[3'(3'd7 - bit_index_ff)];
                  phase_in    = PH_BITSETUP;
               end
               PH_BITSETUP: begin
                  scl_line_in = 1'b1;
                  phase_in    = PH_BITHIGH;
               end
               PH_BITHIGH: begin
                  scl_line_in = 1'b0;
                  if (bit_index_ff == 3'd7) begin
                     // last bit out, let go of sda for the ack
                     sda_line_in = 1'b1;
                     phase_in    = PH_ACKLOW;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in     = PH_BITLOW;
                  end
               end
               PH_ACKLOW: begin
                  scl_line_in = 1'b1;
                  phase_in    = PH_ACKH1;
               end
               PH_ACKH1: begin
                  // mid-point of the scl high time of the ack bit
                  ack_done = 1'b1;
                  acked    = !req_data.sda_level;
                  phase_in = PH_ACKH2;
               end
               PH_ACKH2: begin
                  scl_line_in = 1'b0;
                  sda_line_in = 1'b0;
                  phase_in    = PH_IDLE;
               end
               PH_STOPLOW: begin
                  scl_line_in = 1'b1;
                  phase_in    = PH_STOPHIGH;
               end
               default: begin
                  // stop high done, sda rising is the stop condition
                  sda_line_in = 1'b1;
                  phase_in    = PH_IDLE;
               end
            endcase
         end
      end else begin
         unique case (req_data.action)
            i2cwe_pkg::ACT_START: begin
               scl_line_in   = 1'b1;
               sda_line_in   = 1'b1;
               tick_count_in = '0;
               phase_in      = PH_BUSFREE;
            end
            i2cwe_pkg::ACT_SEND: begin
               shift_byte_in = req_data.byte_value;
               bit_index_in  = '0;
               scl_line_in   = 1'b0;
               tick_count_in = '0;
               phase_in      = PH_BITLOW;
            end
            i2cwe_pkg::ACT_STOP: begin
               scl_line_in   = 1'b0;
               sda_line_in   = 1'b0;
               tick_count_in = '0;
               phase_in      = PH_STOPLOW;
            end
            default: begin
               // plain tick while idle, nothing moves
               phase_in = PH_IDLE;
            end
         endcase
      end

      rsp_data_in.scl_release = scl_line_in;
      rsp_data_in.sda_release = sda_line_in;
      rsp_data_in.busy_res    = (phase_in != PH_IDLE);
      rsp_data_in.ack_done    = ack_done;
      rsp_data_in.acked       = acked;
      rsp_data_in.rejected    = rejected;
   end

   // configuration registers, out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff      <= i2cwe_pkg::RST_TARGET_ADDRESS;
         bus_free_ticks_ff      <= i2cwe_pkg::RST_BUS_FREE_TICKS;
         bit_low_ticks_ff       <= i2cwe_pkg::RST_BIT_LOW_TICKS;
         data_setup_ticks_ff    <= i2cwe_pkg::RST_DATA_SETUP_TICKS;
         bit_high_ticks_ff      <= i2cwe_pkg::RST_BIT_HIGH_TICKS;
         ack_low_ticks_ff       <= i2cwe_pkg::RST_ACK_LOW_TICKS;
         ack_half_high_ticks_ff <= i2cwe_pkg::RST_ACK_HALF_HIGH_TICKS;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cwe_pkg::REG_TARGET_ADDRESS:      target_address_ff      <= csr_wdata[6:0];
            i2cwe_pkg::REG_BUS_FREE_TICKS:      bus_free_ticks_ff      <= csr_wdata;
            i2cwe_pkg::REG_BIT_LOW_TICKS:       bit_low_ticks_ff       <= csr_wdata;
            i2cwe_pkg::REG_DATA_SETUP_TICKS:    data_setup_ticks_ff    <= csr_wdata;
            i2cwe_pkg::REG_BIT_HIGH_TICKS:      bit_high_ticks_ff      <= csr_wdata;
            i2cwe_pkg::REG_ACK_LOW_TICKS:       ack_low_ticks_ff       <= csr_wdata;
            i2cwe_pkg::REG_ACK_HALF_HIGH_TICKS: ack_half_high_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         scl_line_ff   <= 1'b1;
         sda_line_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            bit_index_ff  <= bit_index_in;
            shift_byte_ff <= shift_byte_in;
            scl_line_ff   <= scl_line_in;
            sda_line_ff   <= sda_line_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // ack status is only reported together with an ack sample
   a_acked_needs_ack_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.acked) |-> rsp_data_ff.ack_done)
      else $error("acked set without ack_done");

   // a command taken while idle is never flagged as rejected
   a_idle_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_IDLE) |=> !rsp_data_ff.rejected)
      else $error("command rejected while idle");

   // sequencer only moves on an accepted transaction
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(phase_ff) && $stable(tick_count_ff) && $stable(scl_line_ff)))
      else $error("sequencer state changed without a transaction");

   // reported busy flag matches the sequencer phase
   a_busy_matches_phase: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_data_ff.busy_res == (phase_ff != PH_IDLE)))
      else $error("busy flag disagrees with phase");
`endif

endmodule
